// ===== design/sliding_window_slope_regression_macros.svh =====
// Assertion macros shared by the sliding window slope regression RTL.
// Expects signals named clk and arst_n in the including module.
`ifndef SLIDING_WINDOW_SLOPE_REGRESSION_MACROS_SVH
`define SLIDING_WINDOW_SLOPE_REGRESSION_MACROS_SVH

// same-cycle implication
`define SWSR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swsr check failed");

// next-cycle implication
`define SWSR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swsr check failed");

`endif

// ===== design/swsr_pkg.sv =====
// Shared types and constants for the sliding window slope regression block.
// No dependencies.
package swsr_pkg;

	localparam int WINDOW_DEF = 60;
	localparam int WINDOW_MAX = 256;

	localparam int TIME_W = 23;
	localparam int TEMP_W = 16;
	localparam int DEC_W  = 8;

	// accumulator widths, sized for the largest window
	localparam int SX_W  = 32;
	localparam int SY_W  = 25;
	localparam int SXX_W = 55;
	localparam int XX_W  = 46;
	localparam int XY_W  = 40;
	localparam int SXY_W = 49;

	localparam int MA_W  = 56;
	localparam int MB_W  = 33;
	localparam int P_W   = MA_W + MB_W;
	localparam int DEN_W = 64;
	localparam int NUM_W = 82;
	localparam int RES_W = 40;
	localparam int SLOPE_W = 32;

	localparam logic [RES_W-1:0] SLOPE_LIM = 40'h00_7FFF_FFFF;
	localparam logic [RES_W-1:0] ICPT_LIM  = 40'h7F_FFFF_FFFF;

	localparam logic [DEC_W-1:0]         DEC_RESET  = 8'd10;
	localparam logic signed [TEMP_W-1:0] FILL_RESET = 16'sd6400;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FILL_TEMP  = 2'd1;

	typedef struct packed {
		logic fill;
		logic move;
	} cell_ctrl_t;

endpackage

// ===== design/swsr_cell.sv =====
// One window slot: holds a (time, temperature) pair and takes its neighbor's.
// Depends on swsr_pkg.
module swsr_cell #(
	parameter int INDEX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swsr_pkg::cell_ctrl_t                ctrl,
	input  logic [swsr_pkg::TIME_W-1:0]         nxt_time,
	input  logic signed [swsr_pkg::TEMP_W-1:0]  nxt_temp,
	input  logic signed [swsr_pkg::TEMP_W-1:0]  fill_temp,
	output logic [swsr_pkg::TIME_W-1:0]         time_val,
	output logic signed [swsr_pkg::TEMP_W-1:0]  temp_val
);

	logic [swsr_pkg::TIME_W-1:0]        time_q;
	logic signed [swsr_pkg::TEMP_W-1:0] temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= swsr_pkg::TIME_W'(INDEX);
			temp_q <= swsr_pkg::FILL_RESET;
		end else if (ctrl.fill) begin
			time_q <= swsr_pkg::TIME_W'(INDEX);
			temp_q <= fill_temp;
		end else if (ctrl.move) begin
			time_q <= nxt_time;
			temp_q <= nxt_temp;
		end
	end

	assign time_val = time_q;
	assign temp_val = temp_q;

endmodule

// ===== design/swsr_mul.sv =====
// Bit-serial signed multiplier, one multiplier bit per cycle.
// Depends on swsr_pkg.
module swsr_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [swsr_pkg::MA_W-1:0]  a,
	input  logic signed [swsr_pkg::MB_W-1:0]  b,
	output logic                              busy,
	output logic                              done,
	output logic signed [swsr_pkg::P_W-1:0]   product
);

	localparam int CNT_W = $clog2(swsr_pkg::MB_W);

	logic                             busy_q;
	logic                             done_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic signed [swsr_pkg::P_W-1:0]  acc_q;
	logic signed [swsr_pkg::P_W-1:0]  a_q;
	logic signed [swsr_pkg::MB_W-1:0] b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			acc_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				acc_q  <= '0;
				a_q    <= swsr_pkg::P_W'(a);
				b_q    <= b;
			end else if (busy_q) begin
				// top bit of b carries negative weight
				if (b_q[0]) begin
					if (cnt_q == CNT_W'(swsr_pkg::MB_W - 1))
						acc_q <= acc_q - a_q;
					else
						acc_q <= acc_q + a_q;
				end
				a_q   <= a_q <<< 1;
				b_q   <= b_q >>> 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(swsr_pkg::MB_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy    = busy_q;
	assign done    = done_q;
	assign product = acc_q;

endmodule

// ===== design/swsr_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating and saturating.
// Depends on swsr_pkg.
module swsr_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [swsr_pkg::NUM_W-1:0]  num,
	input  logic [swsr_pkg::DEN_W-1:0]         den,
	input  logic [swsr_pkg::RES_W-1:0]         lim,
	output logic                               busy,
	output logic                               done,
	output logic signed [swsr_pkg::RES_W-1:0]  res
);

	localparam int CNT_W = $clog2(swsr_pkg::NUM_W);

	logic                              busy_q;
	logic                              fin_q;
	logic                              done_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic                              neg_q;
	logic [swsr_pkg::NUM_W-1:0]        mag_q;
	logic [swsr_pkg::DEN_W:0]          rem_q;
	logic [swsr_pkg::DEN_W-1:0]        den_q;
	logic [swsr_pkg::RES_W-1:0]        lim_q;
	logic signed [swsr_pkg::RES_W-1:0] res_q;

	logic [swsr_pkg::DEN_W:0]   rem_t;
	logic                       ge;
	logic [swsr_pkg::RES_W-1:0] lim_p1;
	logic                       big;
	logic [swsr_pkg::RES_W-1:0] mag_sat;
	logic [swsr_pkg::RES_W-1:0] res_c;

	always_comb begin
		rem_t   = {rem_q[swsr_pkg::DEN_W-1:0], mag_q[swsr_pkg::NUM_W-1]};
		ge      = rem_t >= {1'b0, den_q};
		lim_p1  = lim_q + 1'b1;
		big     = neg_q ? (mag_q > swsr_pkg::NUM_W'(lim_p1))
		                : (mag_q > swsr_pkg::NUM_W'(lim_q));
		mag_sat = big ? (neg_q ? lim_p1 : lim_q) : mag_q[swsr_pkg::RES_W-1:0];
		res_c   = neg_q ? (~mag_sat + 1'b1) : mag_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			lim_q  <= '0;
			res_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q && !fin_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				neg_q  <= num[swsr_pkg::NUM_W-1];
				mag_q  <= num[swsr_pkg::NUM_W-1] ? -num : num;
				rem_q  <= '0;
				den_q  <= den;
				lim_q  <= lim;
			end else if (busy_q) begin
				rem_q <= ge ? (rem_t - {1'b0, den_q}) : rem_t;
				mag_q <= {mag_q[swsr_pkg::NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(swsr_pkg::NUM_W - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				res_q  <= $signed(res_c);
				done_q <= 1'b1;
			end
		end
	end

	assign busy = busy_q || fin_q;
	assign done = done_q;
	assign res  = res_q;

endmodule

// ===== design/sliding_window_slope_regression.sv =====
// Sliding window least-squares slope and intercept fitter, top level.
// Depends on swsr_pkg, swsr_cell, swsr_mul, swsr_div and the macros header.
//
// Input channel (in_valid/in_ready): func, time_seconds, temperature. A clear
// (func 1) refills the window with fill_temperature and times 0..WINDOW-1 in
// the transfer cycle and gives no result. A sample (func 0) shifts the pair
// in on one tick of every decimation+1, then fits a line over the window.
// Output channel (out_valid/out_ready): slope, intercept, degenerate, shifted,
// one result per sample.
// Config channel (cfg_valid/cfg_ready, always ready): cfg_index 0 decimation,
// 1 fill_temperature; other indexes are dropped. Write only while idle.
// Operation: the cell chain makes a full rotation past one accumulator, then
// four serial multiplies and two serial divides follow (the divides are
// skipped when degenerate). One sample is worked at a time; in_ready is high
// only between samples.
// A finished result sits in the output register; a new sample is accepted
// while it waits, and the following result holds until the receiver takes
// the old one. Reset restores the register defaults, the initial window and
// a zero tick counter, with no output pending.
`include "sliding_window_slope_regression_macros.svh"

module sliding_window_slope_regression #(
	parameter int WINDOW = swsr_pkg::WINDOW_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    func,
	input  logic [swsr_pkg::TIME_W-1:0]             time_seconds,
	input  logic signed [swsr_pkg::TEMP_W-1:0]      temperature,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [swsr_pkg::SLOPE_W-1:0]     slope,
	output logic signed [swsr_pkg::RES_W-1:0]       intercept,
	output logic                                    degenerate,
	output logic                                    shifted,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [swsr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [swsr_pkg::TEMP_W-1:0]             cfg_data
);

	localparam int IDX_W = $clog2(WINDOW);
	localparam logic [swsr_pkg::DEN_W-1:0] N_DEN = swsr_pkg::DEN_W'(WINDOW);
	localparam logic signed [swsr_pkg::NUM_W-1:0] N_NUM = swsr_pkg::NUM_W'(WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE, ST_ROT, ST_DRAIN, ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_DONE
	} state_t;

	state_t                                 state_q;
	logic [IDX_W-1:0]                       rot_cnt_q;
	logic [1:0]                             mop_q;
	logic                                   dop_q;
	logic [swsr_pkg::DEC_W-1:0]             tick_cnt_q;
	logic [swsr_pkg::DEC_W-1:0]             dec_q;
	logic signed [swsr_pkg::TEMP_W-1:0]     fill_q;
	logic                                   shifted_r_q;
	logic [swsr_pkg::SX_W-1:0]              sx_q;
	logic signed [swsr_pkg::SY_W-1:0]       sy_q;
	logic [swsr_pkg::SXX_W-1:0]             sxx_q;
	logic signed [swsr_pkg::SXY_W-1:0]      sxy_q;
	logic [swsr_pkg::DEN_W-1:0]             den_q;
	logic signed [swsr_pkg::NUM_W-1:0]      slope_num_q;
	logic signed [swsr_pkg::NUM_W-1:0]      inum_q;
	logic signed [swsr_pkg::SLOPE_W-1:0]    slope_r_q;
	logic signed [swsr_pkg::RES_W-1:0]      icpt_r_q;
	logic                                   degen_r_q;
	logic                                   out_valid_q;
	logic signed [swsr_pkg::SLOPE_W-1:0]    slope_q;
	logic signed [swsr_pkg::RES_W-1:0]      icpt_q;
	logic                                   degen_q;
	logic                                   shifted_q;

	logic                                   v_s1;
	logic [swsr_pkg::TIME_W-1:0]            x_s1;
	logic signed [swsr_pkg::TEMP_W-1:0]     y_s1;
	logic [swsr_pkg::XX_W-1:0]              xx_s1;
	logic signed [swsr_pkg::XY_W-1:0]       xy_s1;

	logic [swsr_pkg::TIME_W-1:0]            cell_time [WINDOW];
	logic signed [swsr_pkg::TEMP_W-1:0]     cell_temp [WINDOW];
	logic [swsr_pkg::TIME_W-1:0]            feed_time;
	logic signed [swsr_pkg::TEMP_W-1:0]     feed_temp;
	swsr_pkg::cell_ctrl_t                   cell_ctrl;

	logic                                   in_xfer;
	logic                                   do_shift;
	logic                                   out_load;

	logic                                   mul_start;
	logic signed [swsr_pkg::MA_W-1:0]       mul_a;
	logic signed [swsr_pkg::MB_W-1:0]       mul_b;
	logic                                   mul_busy;
	logic                                   mul_done;
	logic signed [swsr_pkg::P_W-1:0]        mul_p;
	logic signed [swsr_pkg::NUM_W-1:0]      p_num;
	logic signed [swsr_pkg::NUM_W-1:0]      snum;

	logic                                   div_start;
	logic signed [swsr_pkg::NUM_W-1:0]      div_num;
	logic [swsr_pkg::RES_W-1:0]             div_lim;
	logic                                   div_busy;
	logic                                   div_done;
	logic signed [swsr_pkg::RES_W-1:0]      div_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && in_ready;
	assign do_shift  = tick_cnt_q >= dec_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// on a shift the newest pair enters at the tail, on rotation the head wraps
	assign feed_time = (state_q == ST_ROT) ? cell_time[0] : time_seconds;
	assign feed_temp = (state_q == ST_ROT) ? cell_temp[0] : temperature;
	assign cell_ctrl.fill = in_xfer && func;
	assign cell_ctrl.move = (in_xfer && !func && do_shift) || (state_q == ST_ROT);

	genvar g;
	generate
		for (g = 0; g < WINDOW; g++) begin : g_cell
			if (g == WINDOW - 1) begin : g_tail
				swsr_cell #(.INDEX(g)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (cell_ctrl),
					.nxt_time  (feed_time),
					.nxt_temp  (feed_temp),
					.fill_temp (fill_q),
					.time_val  (cell_time[g]),
					.temp_val  (cell_temp[g])
				);
			end else begin : g_body
				swsr_cell #(.INDEX(g)) u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (cell_ctrl),
					.nxt_time  (cell_time[g+1]),
					.nxt_temp  (cell_temp[g+1]),
					.fill_temp (fill_q),
					.time_val  (cell_time[g]),
					.temp_val  (cell_temp[g])
				);
			end
		end
	endgenerate

	// product stage for the head cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			x_s1  <= '0;
			y_s1  <= '0;
			xx_s1 <= '0;
			xy_s1 <= '0;
		end else begin
			v_s1  <= (state_q == ST_ROT);
			x_s1  <= cell_time[0];
			y_s1  <= cell_temp[0];
			xx_s1 <= swsr_pkg::XX_W'(cell_time[0]) * swsr_pkg::XX_W'(cell_time[0]);
			xy_s1 <= swsr_pkg::XY_W'($signed({1'b0, cell_time[0]}))
			       * swsr_pkg::XY_W'(cell_temp[0]);
		end
	end

	always_comb begin
		case (mop_q)
			2'd0: begin
				mul_a = $signed(swsr_pkg::MA_W'(sx_q));
				mul_b = $signed(swsr_pkg::MB_W'(sx_q));
			end
			2'd1: begin
				mul_a = swsr_pkg::MA_W'(sy_q);
				mul_b = $signed(swsr_pkg::MB_W'(sx_q));
			end
			2'd2: begin
				mul_a = $signed(swsr_pkg::MA_W'(sxx_q));
				mul_b = swsr_pkg::MB_W'(sy_q);
			end
			default: begin
				mul_a = swsr_pkg::MA_W'(sxy_q);
				mul_b = $signed(swsr_pkg::MB_W'(sx_q));
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL_GO);
	assign p_num     = swsr_pkg::NUM_W'(mul_p);
	assign snum      = N_NUM * swsr_pkg::NUM_W'(sxy_q) - p_num;

	assign div_start = (state_q == ST_DIV_GO);
	assign div_num   = dop_q ? inum_q : slope_num_q;
	assign div_lim   = dop_q ? swsr_pkg::ICPT_LIM : swsr_pkg::SLOPE_LIM;

	swsr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.busy    (mul_busy),
		.done    (mul_done),
		.product (mul_p)
	);

	swsr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (den_q),
		.lim    (div_lim),
		.busy   (div_busy),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rot_cnt_q   <= '0;
			mop_q       <= '0;
			dop_q       <= 1'b0;
			tick_cnt_q  <= '0;
			dec_q       <= swsr_pkg::DEC_RESET;
			fill_q      <= swsr_pkg::FILL_RESET;
			shifted_r_q <= 1'b0;
			sx_q        <= '0;
			sy_q        <= '0;
			sxx_q       <= '0;
			sxy_q       <= '0;
			den_q       <= '0;
			slope_num_q <= '0;
			inum_q      <= '0;
			slope_r_q   <= '0;
			icpt_r_q    <= '0;
			degen_r_q   <= 1'b0;
			out_valid_q <= 1'b0;
			slope_q     <= '0;
			icpt_q      <= '0;
			degen_q     <= 1'b0;
			shifted_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == swsr_pkg::REG_DECIMATION)
					dec_q <= cfg_data[swsr_pkg::DEC_W-1:0];
				else if (cfg_index == swsr_pkg::REG_FILL_TEMP)
					fill_q <= $signed(cfg_data);
			end

			if (v_s1) begin
				sx_q  <= sx_q + swsr_pkg::SX_W'(x_s1);
				sy_q  <= sy_q + swsr_pkg::SY_W'(y_s1);
				sxx_q <= sxx_q + swsr_pkg::SXX_W'(xx_s1);
				sxy_q <= sxy_q + swsr_pkg::SXY_W'(xy_s1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				slope_q     <= slope_r_q;
				icpt_q      <= icpt_r_q;
				degen_q     <= degen_r_q;
				shifted_q   <= shifted_r_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (func) begin
							tick_cnt_q <= '0;
						end else begin
							if (do_shift)
								tick_cnt_q <= '0;
							else
								tick_cnt_q <= tick_cnt_q + 1'b1;
							shifted_r_q <= do_shift;
							sx_q        <= '0;
							sy_q        <= '0;
							sxx_q       <= '0;
							sxy_q       <= '0;
							rot_cnt_q   <= '0;
							state_q     <= ST_ROT;
						end
					end
				end
				ST_ROT: begin
					rot_cnt_q <= rot_cnt_q + 1'b1;
					if (rot_cnt_q == IDX_W'(WINDOW - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					mop_q   <= '0;
					state_q <= ST_MUL_GO;
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (mul_done) begin
						mop_q <= mop_q + 1'b1;
						case (mop_q)
							2'd0: den_q <= N_DEN * swsr_pkg::DEN_W'(sxx_q)
							             - swsr_pkg::DEN_W'(mul_p);
							2'd1: slope_num_q <= snum <<< 8;
							2'd2: inum_q <= p_num;
							default: inum_q <= inum_q - p_num;
						endcase
						if (mop_q == 2'd3) begin
							if (den_q == '0) begin
								degen_r_q <= 1'b1;
								slope_r_q <= '0;
								icpt_r_q  <= '0;
								state_q   <= ST_DONE;
							end else begin
								degen_r_q <= 1'b0;
								dop_q     <= 1'b0;
								state_q   <= ST_DIV_GO;
							end
						end else begin
							state_q <= ST_MUL_GO;
						end
					end
				end
				ST_DIV_GO: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (dop_q) begin
							icpt_r_q <= div_res;
							state_q  <= ST_DONE;
						end else begin
							slope_r_q <= div_res[swsr_pkg::SLOPE_W-1:0];
							dop_q     <= 1'b1;
							state_q   <= ST_DIV_GO;
						end
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign slope      = slope_q;
	assign intercept  = icpt_q;
	assign degenerate = degen_q;
	assign shifted    = shifted_q;

	`SWSR_ASSERT_IMP(a_mul_start_idle, mul_start, !mul_busy)
	`SWSR_ASSERT_IMP(a_div_start_idle, div_start, !div_busy)
	`SWSR_ASSERT_IMP(a_degen_zero, out_valid_q && degen_q, slope_q == '0 && icpt_q == '0)
	`SWSR_ASSERT_NXT(a_clear_cnt, in_valid && in_ready && func, tick_cnt_q == '0)
	`SWSR_ASSERT_IMP(a_ready_units_idle, in_ready, !mul_busy && !div_busy)

endmodule

// ===== tb/sliding_window_slope_regression_chk.sv =====
// Checker for the sliding window slope regression block: tracks the window,
// fits the line for every sample transfer and compares each result transfer.
// Depends on swsr_pkg.
module sliding_window_slope_regression_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                func,
	input  logic [swsr_pkg::TIME_W-1:0]         time_seconds,
	input  logic signed [swsr_pkg::TEMP_W-1:0]  temperature,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [swsr_pkg::SLOPE_W-1:0] slope,
	input  logic signed [swsr_pkg::RES_W-1:0]   intercept,
	input  logic                                degenerate,
	input  logic                                shifted,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [swsr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swsr_pkg::TEMP_W-1:0]         cfg_data,
	output int                                  errors,
	output int                                  pending,
	output int                                  fits_seen,
	output int                                  flat_fits
);
	import swsr_pkg::*;

	localparam int N = WINDOW_DEF;

	typedef struct packed {
		logic signed [SLOPE_W-1:0] slope;
		logic signed [RES_W-1:0]   intercept;
		logic                      degenerate;
		logic                      shifted;
	} fit_t;

	logic [TIME_W-1:0]        win_time [N];
	logic signed [TEMP_W-1:0] win_temp [N];
	logic [DEC_W-1:0]         tick_cnt;
	logic [DEC_W-1:0]         decim;
	logic signed [TEMP_W-1:0] fill_temp;
	fit_t                     fit_q [$];

	task automatic refill();
		for (int i = 0; i < N; i++) begin
			win_time[i] = TIME_W'(i);
			win_temp[i] = fill_temp;
		end
		tick_cnt = '0;
	endtask

	function automatic logic signed [127:0] sat(logic signed [127:0] q,
			logic signed [127:0] lim);
		if (q > lim)
			return lim;
		if (q < -lim - 1)
			return -lim - 1;
		return q;
	endfunction

	// advance the window for one sample and return the fitted line
	task automatic fit_sample(input logic [TIME_W-1:0] t, input logic signed [TEMP_W-1:0] y_in,
			output fit_t r);
		logic signed [127:0] sx, sy, sxx, sxy, x, y, den, num;
		sx = 0; sy = 0; sxx = 0; sxy = 0;
		r = '0;
		if (tick_cnt >= decim) begin
			for (int i = 0; i < N - 1; i++) begin
				win_time[i] = win_time[i+1];
				win_temp[i] = win_temp[i+1];
			end
			win_time[N-1] = t;
			win_temp[N-1] = y_in;
			tick_cnt = '0;
			r.shifted = 1'b1;
		end else begin
			tick_cnt = tick_cnt + 1'b1;
		end
		for (int i = 0; i < N; i++) begin
			x = {105'd0, win_time[i]};
			y = win_temp[i];
			sx += x;
			sy += y;
			sxx += x * x;
			sxy += x * y;
		end
		den = N * sxx - sx * sx;
		if (den == 0) begin
			r.degenerate = 1'b1;
		end else begin
			num = 256 * (N * sxy - sx * sy);
			r.slope = SLOPE_W'(sat(num / den, 128'sh7FFF_FFFF));
			num = sy * sxx - sx * sxy;
			r.intercept = RES_W'(sat(num / den, 128'sh7F_FFFF_FFFF));
		end
	endtask

	assign pending = fit_q.size();

	always @(posedge clk or negedge arst_n) begin
		fit_t exp_fit, got;
		if (!arst_n) begin
			decim = DEC_RESET;
			fill_temp = FILL_RESET;
			refill();
			fit_q.delete();
			errors <= 0;
			fits_seen <= 0;
			flat_fits <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{slope, intercept, degenerate, shifted};
				if (fit_q.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10)
						$display("unexpected result transfer: %p", got);
				end else begin
					exp_fit = fit_q.pop_front();
					fits_seen <= fits_seen + 1;
					if (got.degenerate)
						flat_fits <= flat_fits + 1;
					if (got !== exp_fit) begin
						errors <= errors + 1;
						if (errors < 10)
							$display("mismatch: expected %p, actual %p", exp_fit, got);
					end
				end
			end
			if (in_valid && in_ready) begin
				if (func) begin
					refill();
				end else begin
					fit_sample(time_seconds, temperature, exp_fit);
					fit_q.push_back(exp_fit);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_DECIMATION)
					decim = cfg_data[DEC_W-1:0];
				else if (cfg_index == REG_FILL_TEMP)
					fill_temp = cfg_data;
			end
		end
	end
endmodule

// ===== tb/sliding_window_slope_regression_tb.sv =====
// Testbench top for the sliding window slope regression block: drives the
// sample, result and register channels and gives the verdict.
// Depends on swsr_pkg, the block and sliding_window_slope_regression_chk.
module sliding_window_slope_regression_tb;
	import swsr_pkg::*;

	localparam int LIMIT = 8_000_000;
	localparam int DRAIN = 600;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic                      func = 1'b0;
	logic [TIME_W-1:0]         time_seconds = '0;
	logic signed [TEMP_W-1:0]  temperature = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [SLOPE_W-1:0] slope;
	logic signed [RES_W-1:0]   intercept;
	logic                      degenerate;
	logic                      shifted;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [TEMP_W-1:0]         cfg_data = '0;

	int errors, pending, fits_seen, flat_fits;
	int idle_mode = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;
	int clears = 0;
	int cur_time = 0;
	int cur_temp = 0;

	always #10 clk = ~clk;

	sliding_window_slope_regression uut (.*);

	sliding_window_slope_regression_chk chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls per mode, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 3000;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= (idle_mode == 2) ? ($urandom_range(99) >= 61) :
				(idle_mode == 3) ? ($urandom_range(99) >= 25) : 1'b1;
		end
	end

	task automatic send(input logic f, input logic [TIME_W-1:0] t,
			input logic signed [TEMP_W-1:0] y);
		int gap_pct;
		gap_pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 25 : 0;
		if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < gap_pct);
		end
		in_valid <= 1'b1;
		func <= f;
		time_seconds <= t;
		temperature <= y;
		if (f)
			clears++;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid, then hold until every result is in and the block is quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TEMP_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic sample_walk();
		cur_time = (cur_time + $urandom_range(3)) & 23'h7FFFFF;
		cur_temp = cur_temp + $urandom_range(800) - 400;
		if (cur_temp > 32767) cur_temp = 32767;
		if (cur_temp < -32768) cur_temp = -32768;
		send(1'b0, TIME_W'(cur_time), TEMP_W'(cur_temp));
	endtask

	task automatic random_phase(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 4) begin
				send(1'b1, TIME_W'($urandom), TEMP_W'($urandom));
			end else if (k < 12) begin
				send(1'b0, TIME_W'($urandom), TEMP_W'($urandom));
			end else if (k < 14) begin
				cur_time = $urandom_range(23'h7FFFFF);
				cur_temp = $signed(16'($urandom));
				sample_walk();
			end else begin
				sample_walk();
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, clear, dropped register indexes
		send(1'b0, '0, 16'sh7FFF);
		send(1'b0, 23'h7FFFFF, -16'sh8000);
		send(1'b0, 23'h7FFFFF, 16'sh0000);
		send(1'b1, '0, '0);
		send(1'b0, 23'd1, 16'sh7FFF);
		settle();
		write_reg(2'd2, 16'hFFFF);
		write_reg(2'd3, 16'h0000);
		write_reg(REG_DECIMATION, 16'd0);
		write_reg(REG_FILL_TEMP, 16'h8000);
		send(1'b1, '0, '0);
		send(1'b0, 23'h7FFFFF, 16'sh7FFF);
		send(1'b0, 23'h000000, -16'sh8000);
		send(1'b0, 23'h7FFFFF, 16'sh7FFF);
		send(1'b0, 23'h555555, 16'sh5555);
		send(1'b0, 23'h2AAAAA, -16'sh5556);
		settle();
		// decimation lowered below the running counter
		write_reg(REG_DECIMATION, 16'd255);
		for (int i = 0; i < 12; i++)
			send(1'b0, TIME_W'(100 + i), TEMP_W'(i * 50));
		settle();
		write_reg(REG_DECIMATION, 16'd3);
		send(1'b0, 23'd500, 16'sd1000);
		send(1'b0, 23'd501, 16'sd1001);
		settle();

		// constant time across the whole window gives a degenerate fit
		write_reg(REG_DECIMATION, 16'd0);
		idle_mode = 0;
		for (int i = 0; i < 64; i++)
			send(1'b0, 23'd4242, TEMP_W'($urandom));
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(REG_DECIMATION, 16'd0); write_reg(REG_FILL_TEMP, 16'h7FFF); end
				1: begin write_reg(REG_DECIMATION, 16'd255); write_reg(REG_FILL_TEMP, 16'h8000); end
				2: begin write_reg(REG_DECIMATION, 16'd10); write_reg(REG_FILL_TEMP, 16'd6400); end
				default: begin
					write_reg(REG_DECIMATION, 16'($urandom_range(4)));
					write_reg(REG_FILL_TEMP, 16'($urandom));
				end
			endcase
			idle_mode = ph % 4;
			cur_time = $urandom_range(4294967);
			cur_temp = $signed(16'($urandom));
			send(1'b1, '0, '0);
			if (ph == 4) begin
				// long receiver hold-off while items keep coming
				hold_req++;
				random_phase(20);
			end
			random_phase(ph == 1 ? 60 : 250);
			settle();
		end

		$display("covered %0d fits (%0d degenerate) and %0d clears over several settings",
			fits_seen, flat_fits, clears);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
